>>> rtl/tcg_pkg.sv
`default_nettype none
package tcg_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 128;

	localparam int FUNC_W  = 4;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 7;
	localparam int COUNT_W = 8;
	localparam int CHAR_W  = 21;
	localparam int TATTR_W = 3;
	localparam int CATTR_W = 2;
	localparam int RGB_W   = 24;
	localparam int STYLE_W = 3;
	localparam int CELL_W  = CHAR_W + STYLE_W + 2 * RGB_W;

	localparam int ROWS_CFG_W = 7;
	localparam int COLS_CFG_W = 8;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [FUNC_W-1:0] FN_RESIZE    = 4'd0;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd1;
	localparam logic [FUNC_W-1:0] FN_EOLCLEAR  = 4'd2;
	localparam logic [FUNC_W-1:0] FN_GOTO      = 4'd3;
	localparam logic [FUNC_W-1:0] FN_REGION    = 4'd4;
	localparam logic [FUNC_W-1:0] FN_SCROLL    = 4'd5;
	localparam logic [FUNC_W-1:0] FN_PUT       = 4'd6;
	localparam logic [FUNC_W-1:0] FN_HIGHLIGHT = 4'd7;
	localparam logic [FUNC_W-1:0] FN_READ      = 4'd8;

	localparam logic [TATTR_W-1:0] TA_BOLD      = 3'd1;
	localparam logic [TATTR_W-1:0] TA_UNDERLINE = 3'd2;
	localparam logic [TATTR_W-1:0] TA_UNDERCURL = 3'd3;
	localparam logic [TATTR_W-1:0] TA_ITALIC    = 3'd4;

	localparam logic [CATTR_W-1:0] CA_FG      = 2'd1;
	localparam logic [CATTR_W-1:0] CA_BG      = 2'd2;
	localparam logic [CATTR_W-1:0] CA_REVERSE = 2'd3;

	localparam logic [STYLE_W-1:0] STY_BOLD      = 3'd1;
	localparam logic [STYLE_W-1:0] STY_ITALIC    = 3'd2;
	localparam logic [STYLE_W-1:0] STY_UNDERLINE = 3'd4;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_DFG  = 2'd2;
	localparam logic [1:0] REG_DBG  = 2'd3;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 21'h20;
	localparam logic [RGB_W-1:0]  RGB_MAX    = 24'hFFFFFF;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row_end;
		logic [COL_W-1:0]   col_end;
		logic [COUNT_W-1:0] count;
		logic [CHAR_W-1:0]  char_code;
		logic               hl_reset;
		logic [TATTR_W-1:0] text_attr;
		logic               attr_on;
		logic [CATTR_W-1:0] color_attr;
		logic [RGB_W-1:0]   color_value;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  cell_char;
		logic [STYLE_W-1:0] cell_style;
		logic [RGB_W-1:0]   cell_fg;
		logic [RGB_W-1:0]   cell_bg;
		logic               error;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/tcg_if.sv
`default_nettype none
interface tcg_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcg_pkg::FUNC_W-1:0]    func;
	logic [tcg_pkg::ROW_W-1:0]     row;
	logic [tcg_pkg::COL_W-1:0]     col;
	logic [tcg_pkg::ROW_W-1:0]     row_end;
	logic [tcg_pkg::COL_W-1:0]     col_end;
	logic signed [tcg_pkg::COUNT_W-1:0] count;
	logic [tcg_pkg::CHAR_W-1:0]    char_code;
	logic                          hl_reset;
	logic [tcg_pkg::TATTR_W-1:0]   text_attr;
	logic                          attr_on;
	logic [tcg_pkg::CATTR_W-1:0]   color_attr;
	logic [tcg_pkg::RGB_W-1:0]     color_value;

	modport source (output valid, func, row, col, row_end, col_end, count, char_code,
		hl_reset, text_attr, attr_on, color_attr, color_value, input ready);
	modport sink (input valid, func, row, col, row_end, col_end, count, char_code,
		hl_reset, text_attr, attr_on, color_attr, color_value, output ready);
endinterface

interface tcg_res_if;
	logic                          valid;
	logic                          ready;
	logic [tcg_pkg::CHAR_W-1:0]    cell_char;
	logic [tcg_pkg::STYLE_W-1:0]   cell_style;
	logic [tcg_pkg::RGB_W-1:0]     cell_fg;
	logic [tcg_pkg::RGB_W-1:0]     cell_bg;
	logic                          error;

	modport source (output valid, cell_char, cell_style, cell_fg, cell_bg, error,
		input ready);
	modport sink (input valid, cell_char, cell_style, cell_fg, cell_bg, error,
		output ready);
endinterface
`default_nettype wire

>>> rtl/tcg_ram.sv
`default_nettype none
module tcg_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]    waddr,
	input  wire logic [W-1:0]                          wdata,
	input  wire logic                                  re,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]    raddr,
	output logic      [W-1:0]                          rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/text_cell_grid_engine_top.sv
// Character-cell screen grid. All cells sit in one single-port-write, single-port-read
// RAM of MAX_ROWS*MAX_COLS words; every command takes one word and returns one result
// word. Put, goto, region, highlight, unused codes and a read outside the grid finish
// in the execute state; a read inside the grid also waits for the read data. Clear
// and clear-to-end-of-line then write the cleared cells one by one; scroll first
// copies each moved cell, reading it and writing it to its new row, then blanks the
// rows left behind, or only blanks them if no row is moved; resize blanks all
// MAX_ROWS*MAX_COLS cells. The RAM write port takes one cell per cycle. After reset a
// clearing pass blanks the grid, and no command is taken until it ends. Register
// writes are taken at any time. A result waiting on the output does not hold off
// acceptance of the next command, but it does not finish until the output is free.
`default_nettype none
module text_cell_grid_engine_top #(
	parameter int MAX_ROWS = tcg_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = tcg_pkg::MAX_COLS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tcg_cmd_if.sink                            cmd,
	tcg_res_if.source                          res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcg_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tcg_pkg::PDATA_W-1:0]   pwdata,
	output logic      [tcg_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	localparam int RW = ($clog2(MAX_ROWS + 1) > tcg_pkg::ROW_W) ?
		$clog2(MAX_ROWS + 1) : tcg_pkg::ROW_W;
	localparam int CW = ($clog2(MAX_COLS + 1) > tcg_pkg::COL_W) ?
		$clog2(MAX_COLS + 1) : tcg_pkg::COL_W;
	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = (RW + 1 > 9) ? RW + 1 : 9;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_RDW    = 7'b0000100,
		ST_COPY   = 7'b0001000,
		ST_CDRAIN = 7'b0010000,
		ST_FILL   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		return AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	// configuration
	logic [tcg_pkg::ROWS_CFG_W-1:0] rows_in_use_q;
	logic [tcg_pkg::COLS_CFG_W-1:0] cols_in_use_q;
	logic [tcg_pkg::RGB_W-1:0]      dfg_q, dbg_q;
	logic                           cfg_wr;

	state_t                         state_q;
	tcg_pkg::cmd_t                  cmd_q;
	logic [tcg_pkg::ROW_W-1:0]      cursor_row_q;
	logic [CW-1:0]                  cursor_col_q;
	logic [RW-1:0]                  region_top_q, region_bottom_q, grid_rows_q;
	logic [CW-1:0]                  region_left_q, region_right_q, grid_cols_q;
	logic [tcg_pkg::STYLE_W-1:0]    print_style_q;
	logic [tcg_pkg::RGB_W-1:0]      print_fg_q, print_bg_q;

	logic [RW-1:0]                  f_r_q, f_bot_q, sr_q, send_q;
	logic [CW-1:0]                  f_c_q, lft_q, rgt_q, cc_q;
	logic [RW-1:0]                  n_q;
	logic                           up_q, init_q;
	logic                           cp_vld_s1;
	logic [AW-1:0]                  cp_addr_s1;

	tcg_pkg::res_t                  res_q, out_q, fin_res;
	logic                           out_v_q, fin, out_free;

	// exec decode
	logic [RW-1:0]                  cbot, cur_row_x, rd_row_x;
	logic [CW-1:0]                  crgt, rd_col_x;
	logic                           rect_ok, put_err, rd_err, eol_ok;
	logic [NW-1:0]                  h, n9, nc;
	logic                           up;
	logic [RW-1:0]                  gr_n;
	logic [CW-1:0]                  gc_n;
	logic [tcg_pkg::STYLE_W-1:0]    hl_bit;

	logic                           we, re;
	logic [AW-1:0]                  waddr, raddr;
	logic [tcg_pkg::CELL_W-1:0]     wdata, rdata;
	logic [tcg_pkg::CELL_W-1:0]     blank_cell;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			tcg_pkg::REG_ROWS: prdata = tcg_pkg::PDATA_W'(rows_in_use_q);
			tcg_pkg::REG_COLS: prdata = tcg_pkg::PDATA_W'(cols_in_use_q);
			tcg_pkg::REG_DFG:  prdata = tcg_pkg::PDATA_W'(dfg_q);
			tcg_pkg::REG_DBG:  prdata = tcg_pkg::PDATA_W'(dbg_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= tcg_pkg::ROWS_CFG_W'(64);
			cols_in_use_q <= tcg_pkg::COLS_CFG_W'(128);
			dfg_q         <= '0;
			dbg_q         <= tcg_pkg::RGB_MAX;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tcg_pkg::REG_ROWS: rows_in_use_q <= pwdata[tcg_pkg::ROWS_CFG_W-1:0];
				tcg_pkg::REG_COLS: cols_in_use_q <= pwdata[tcg_pkg::COLS_CFG_W-1:0];
				tcg_pkg::REG_DFG:  dfg_q <= pwdata[tcg_pkg::RGB_W-1:0];
				tcg_pkg::REG_DBG:  dbg_q <= pwdata[tcg_pkg::RGB_W-1:0];
				default: ;
			endcase
		end
	end

	assign blank_cell = {tcg_pkg::BLANK_CHAR, tcg_pkg::STYLE_W'(0), dfg_q, dbg_q};

	// decode of the held command
	always_comb begin
		cbot      = (region_bottom_q >= grid_rows_q) ? grid_rows_q - RW'(1) : region_bottom_q;
		crgt      = (region_right_q >= grid_cols_q) ? grid_cols_q - CW'(1) : region_right_q;
		rect_ok   = (region_top_q <= cbot) && (region_left_q <= crgt);
		cur_row_x = RW'(cursor_row_q);
		rd_row_x  = RW'(cmd_q.row);
		rd_col_x  = CW'(cmd_q.col);
		eol_ok    = (cur_row_x < grid_rows_q) && (cursor_col_q <= region_right_q)
			&& (cursor_col_q <= crgt);
		put_err   = (cur_row_x >= grid_rows_q) || (cursor_col_q >= grid_cols_q);
		rd_err    = (rd_row_x >= grid_rows_q) || (rd_col_x >= grid_cols_q);
		up        = ~cmd_q.count[tcg_pkg::COUNT_W-1];
		n9        = up ? NW'(cmd_q.count) : NW'(9'd256 - {1'b0, cmd_q.count});
		h         = NW'(cbot) - NW'(region_top_q) + NW'(1);
		nc        = (n9 > h) ? h : n9;
		gr_n      = (rows_in_use_q == '0) ? RW'(1) :
			((int'(rows_in_use_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_in_use_q));
		gc_n      = (cols_in_use_q == '0) ? CW'(1) :
			((int'(cols_in_use_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_in_use_q));
		hl_bit    = '0;
		case (cmd_q.text_attr)
			tcg_pkg::TA_BOLD:      hl_bit = tcg_pkg::STY_BOLD;
			tcg_pkg::TA_UNDERLINE: hl_bit = tcg_pkg::STY_UNDERLINE;
			tcg_pkg::TA_UNDERCURL: hl_bit = tcg_pkg::STY_UNDERLINE;
			tcg_pkg::TA_ITALIC:    hl_bit = tcg_pkg::STY_ITALIC;
			default:               hl_bit = '0;
		endcase
	end

	// completion of a command
	always_comb begin
		fin     = 1'b0;
		fin_res = '0;
		case (state_q)
			ST_EXEC: begin
				case (cmd_q.func)
					tcg_pkg::FN_RESIZE: fin = 1'b0;
					tcg_pkg::FN_CLEAR: fin = !rect_ok;
					tcg_pkg::FN_EOLCLEAR: fin = !eol_ok;
					tcg_pkg::FN_SCROLL: fin = !rect_ok || (n9 == '0);
					tcg_pkg::FN_PUT: begin
						fin           = 1'b1;
						fin_res.error = put_err;
					end
					tcg_pkg::FN_READ: begin
						fin           = rd_err;
						fin_res.error = rd_err;
					end
					default: fin = 1'b1;
				endcase
			end
			ST_RDW: begin
				fin = 1'b1;
				{fin_res.cell_char, fin_res.cell_style, fin_res.cell_fg, fin_res.cell_bg} =
					rdata;
			end
			ST_FILL: fin = !init_q && (f_c_q == rgt_q) && (f_r_q == f_bot_q);
			ST_DONE: begin
				fin     = 1'b1;
				fin_res = res_q;
			end
			default: fin = 1'b0;
		endcase
	end

	assign out_free = !out_v_q || res.ready;

	// memory ports
	always_comb begin
		we    = 1'b0;
		waddr = cp_addr_s1;
		wdata = rdata;
		if (cp_vld_s1) begin
			we = 1'b1;
		end else if (state_q == ST_FILL) begin
			we    = 1'b1;
			waddr = cell_addr(f_r_q, f_c_q);
			wdata = blank_cell;
		end else if (state_q == ST_EXEC && cmd_q.func == tcg_pkg::FN_PUT && !put_err) begin
			we    = 1'b1;
			waddr = cell_addr(cur_row_x, cursor_col_q);
			wdata = {cmd_q.char_code, print_style_q, print_fg_q, print_bg_q};
		end
		re    = 1'b0;
		raddr = cell_addr(sr_q, cc_q);
		if (state_q == ST_COPY) begin
			re = 1'b1;
		end else if (state_q == ST_EXEC && cmd_q.func == tcg_pkg::FN_READ && !rd_err) begin
			re    = 1'b1;
			raddr = cell_addr(rd_row_x, rd_col_x);
		end
	end

	tcg_ram #(.W(tcg_pkg::CELL_W), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd.ready      = (state_q == ST_IDLE);
	assign res.valid      = out_v_q;
	assign res.cell_char  = out_q.cell_char;
	assign res.cell_style = out_q.cell_style;
	assign res.cell_fg    = out_q.cell_fg;
	assign res.cell_bg    = out_q.cell_bg;
	assign res.error      = out_q.error;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			cmd_q <= '{func: cmd.func, row: cmd.row, col: cmd.col, row_end: cmd.row_end,
				col_end: cmd.col_end, count: cmd.count, char_code: cmd.char_code,
				hl_reset: cmd.hl_reset, text_attr: cmd.text_attr, attr_on: cmd.attr_on,
				color_attr: cmd.color_attr, color_value: cmd.color_value};
		end
		if (fin) begin
			res_q <= fin_res;
			if (out_free) begin
				out_q <= fin_res;
			end
		end
		cp_addr_s1 <= cell_addr(up_q ? sr_q - n_q : sr_q + n_q, cc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_FILL;
			init_q          <= 1'b1;
			f_r_q           <= '0;
			f_c_q           <= '0;
			f_bot_q         <= RW'(MAX_ROWS - 1);
			lft_q           <= '0;
			rgt_q           <= CW'(MAX_COLS - 1);
			sr_q            <= '0;
			send_q          <= '0;
			cc_q            <= '0;
			n_q             <= '0;
			up_q            <= 1'b0;
			cp_vld_s1       <= 1'b0;
			out_v_q         <= 1'b0;
			cursor_row_q    <= '0;
			cursor_col_q    <= '0;
			region_top_q    <= '0;
			region_bottom_q <= RW'(MAX_ROWS - 1);
			region_left_q   <= '0;
			region_right_q  <= CW'(MAX_COLS - 1);
			grid_rows_q     <= RW'(MAX_ROWS);
			grid_cols_q     <= CW'(MAX_COLS);
			print_style_q   <= '0;
			print_fg_q      <= '0;
			print_bg_q      <= tcg_pkg::RGB_MAX;
		end else begin
			cp_vld_s1 <= (state_q == ST_COPY);
			if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			if (fin) begin
				if (out_free) begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end else begin
					state_q <= ST_DONE;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.func)
						tcg_pkg::FN_RESIZE: begin
							grid_rows_q     <= gr_n;
							grid_cols_q     <= gc_n;
							region_top_q    <= '0;
							region_left_q   <= '0;
							region_bottom_q <= gr_n - RW'(1);
							region_right_q  <= gc_n - CW'(1);
							cursor_row_q    <= '0;
							cursor_col_q    <= '0;
							f_r_q           <= '0;
							f_bot_q         <= RW'(MAX_ROWS - 1);
							f_c_q           <= '0;
							lft_q           <= '0;
							rgt_q           <= CW'(MAX_COLS - 1);
							state_q         <= ST_FILL;
						end
						tcg_pkg::FN_CLEAR: begin
							f_r_q   <= region_top_q;
							f_bot_q <= cbot;
							f_c_q   <= region_left_q;
							lft_q   <= region_left_q;
							rgt_q   <= crgt;
							if (rect_ok) begin
								state_q <= ST_FILL;
							end
						end
						tcg_pkg::FN_EOLCLEAR: begin
							f_r_q   <= cur_row_x;
							f_bot_q <= cur_row_x;
							f_c_q   <= cursor_col_q;
							lft_q   <= cursor_col_q;
							rgt_q   <= crgt;
							if (eol_ok) begin
								state_q <= ST_FILL;
							end
						end
						tcg_pkg::FN_GOTO: begin
							cursor_row_q <= cmd_q.row;
							cursor_col_q <= CW'(cmd_q.col);
						end
						tcg_pkg::FN_REGION: begin
							region_top_q    <= RW'(cmd_q.row);
							region_left_q   <= CW'(cmd_q.col);
							region_bottom_q <= RW'(cmd_q.row_end);
							region_right_q  <= CW'(cmd_q.col_end);
						end
						tcg_pkg::FN_SCROLL: begin
							n_q   <= RW'(nc);
							up_q  <= up;
							lft_q <= region_left_q;
							rgt_q <= crgt;
							cc_q  <= region_left_q;
							f_c_q <= region_left_q;
							if (up) begin
								sr_q    <= region_top_q + RW'(nc);
								send_q  <= cbot;
								f_r_q   <= cbot - RW'(nc) + RW'(1);
								f_bot_q <= cbot;
							end else begin
								sr_q    <= cbot - RW'(nc);
								send_q  <= region_top_q;
								f_r_q   <= region_top_q;
								f_bot_q <= region_top_q + RW'(nc) - RW'(1);
							end
							if (rect_ok && n9 != '0) begin
								state_q <= (nc < h) ? ST_COPY : ST_FILL;
							end
						end
						tcg_pkg::FN_PUT: begin
							if (!put_err) begin
								cursor_col_q <= cursor_col_q + CW'(1);
							end
						end
						tcg_pkg::FN_HIGHLIGHT: begin
							if (cmd_q.hl_reset) begin
								print_style_q <= '0;
								print_fg_q    <= dfg_q;
								print_bg_q    <= dbg_q;
							end else begin
								print_style_q <= cmd_q.attr_on ? (print_style_q | hl_bit)
									: (print_style_q & ~hl_bit);
								case (cmd_q.color_attr)
									tcg_pkg::CA_FG: print_fg_q <= cmd_q.color_value;
									tcg_pkg::CA_BG: print_bg_q <= cmd_q.color_value;
									tcg_pkg::CA_REVERSE: begin
										print_fg_q <= tcg_pkg::RGB_MAX - print_fg_q;
										print_bg_q <= tcg_pkg::RGB_MAX - print_bg_q;
									end
									default: ;
								endcase
							end
						end
						tcg_pkg::FN_READ: begin
							if (!rd_err) begin
								state_q <= ST_RDW;
							end
						end
						default: ;
					endcase
				end
				ST_COPY: begin
					if (cc_q == rgt_q) begin
						cc_q <= lft_q;
						if (sr_q == send_q) begin
							state_q <= ST_CDRAIN;
						end else begin
							sr_q <= up_q ? sr_q + RW'(1) : sr_q - RW'(1);
						end
					end else begin
						cc_q <= cc_q + CW'(1);
					end
				end
				ST_CDRAIN: state_q <= ST_FILL;
				ST_FILL: begin
					if (f_c_q == rgt_q) begin
						f_c_q <= lft_q;
						if (f_r_q == f_bot_q) begin
							if (init_q) begin
								init_q  <= 1'b0;
								state_q <= ST_IDLE;
							end
						end else begin
							f_r_q <= f_r_q + RW'(1);
						end
					end else begin
						f_c_q <= f_c_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
